// ===== sv/ishp_pkg.sv =====
// Package for the IPMI session header parser.
// Holds the item types, result kind codes, parse phases and header constants.
// No dependencies.
`default_nettype none

package ishp_pkg;

	// One input item: a byte of the session wrapper and its end-of-packet mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  byte_out;
		logic        final_item;
		logic [31:0] session_number;
		logic [31:0] sequence_number;
		logic [7:0]  auth_kind;
		logic [5:0]  payload_kind;
		logic        is_authenticated;
		logic        is_encrypted;
		logic [15:0] message_length;
		logic        route;
		logic [47:0] oem_fields;
	} rsp_t;

	// Result kinds.
	localparam logic [2:0] KIND_HEADER    = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
	localparam logic [2:0] KIND_TRAILER   = 3'd2;
	localparam logic [2:0] KIND_HDR_TRUNC = 3'd3;
	localparam logic [2:0] KIND_PLD_SHORT = 3'd4;

	// Parse phase of the current packet.
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	// Authentication type codes.
	localparam logic [7:0] AUTH_RMCPP = 8'h06;
	localparam logic [7:0] AUTH_NONE  = 8'h00;

	// RMCP+ payload type OEM explicit; the type sits in bits 5..0.
	localparam logic [5:0] PT_OEM_EXPLICIT = 6'd2;

	// Header lengths in bytes for the four layouts.
	localparam logic [4:0] HLEN_V2      = 5'd12;
	localparam logic [4:0] HLEN_V2_OEM  = 5'd18;
	localparam logic [4:0] HLEN_V15     = 5'd10;
	localparam logic [4:0] HLEN_V15_AUTH = 5'd26;

	// First byte offsets of the session fields in the v2.0 layout.
	localparam logic [4:0] V2_BASE     = 5'd2;
	localparam logic [4:0] V2_BASE_OEM = 5'd8;

	// Offset of the length byte in the v1.5 layouts.
	localparam logic [4:0] V15_LEN_AT      = 5'd9;
	localparam logic [4:0] V15_LEN_AT_AUTH = 5'd25;

endpackage

`default_nettype wire

// ===== sv/ipmi_session_header_parser_top.sv =====
// Top level of the IPMI session header parser.
// Depends on ishp_pkg for item types, kind codes and header constants.
`default_nettype none

// Usage
// The request channel (req_valid, req_stall, req_item) carries one byte of
// an IPMI LAN session wrapper per item, with end_of_packet set on the last
// byte of each packet. An item is taken at a rising edge where req_valid is
// high and req_stall is low.
// The response channel (rsp_valid, rsp_stall, rsp_item) carries at most one
// result item per byte: the header summary when the last header byte
// arrives, then each payload byte, then each trailer byte. A packet that
// ends inside the header or inside the payload is flagged by its kind.
// Header bytes before the last one give no result unless they end the packet.
// A byte accepted at an edge is held in the input register and decoded from
// there; its result is loaded into the result register and offered from it.
// Throughput: one byte per cycle while the receiver does not stall; the
// only loop is the parse state update.
// When rsp_stall holds a result, an empty input register still takes one
// byte; after that req_stall stays high until the result is taken.
// Reset clears both registers and returns the parser to the start of a
// packet header. The parser also returns there after every end-of-packet.

module ipmi_session_header_parser_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ishp_pkg::req_t req_item,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ishp_pkg::rsp_t     rsp_item
);

	// Input and result registers.
	logic            valid_s1;
	ishp_pkg::req_t  item_s1;
	logic            valid_s2;
	ishp_pkg::rsp_t  res_s2;

	// Parse state of the current packet.
	ishp_pkg::phase_t phase_q;
	logic [4:0]       hdr_idx_q;
	logic [7:0]       auth_q;
	logic [7:0]       ptype_q;
	logic [31:0]      sess_q;
	logic [31:0]      seq_q;
	logic [47:0]      oem_q;
	logic [15:0]      len_q;
	logic [15:0]      remain_q;

	// Next-state values and decode signals.
	ishp_pkg::phase_t phase_n;
	logic [4:0]       hdr_idx_n;
	logic [7:0]       auth_n;
	logic [7:0]       ptype_n;
	logic [31:0]      sess_n;
	logic [31:0]      seq_n;
	logic [47:0]      oem_n;
	logic [15:0]      len_n;
	logic [15:0]      remain_n;

	logic             accept;
	logic             adv;
	logic             has_res;
	ishp_pkg::rsp_t   res;

	logic [7:0]       b;
	logic             eop;
	logic [4:0]       idx;
	logic [5:0]       idx_inc;
	logic [4:0]       base;
	logic [4:0]       off;
	logic [2:0]       oem_lane;
	logic [4:0]       len_at;
	logic             v2_n;
	logic             oem_sel_n;
	logic [4:0]       hlen;
	logic             hdr_done;
	logic [7:0]       pt;
	logic [15:0]      rem_dec;

	// The result register can take a new item when it is empty or its item
	// leaves in this cycle. The byte in the input register is then processed.
	assign adv       = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	assign b       = item_s1.data_byte;
	assign eop     = item_s1.end_of_packet;
	assign idx     = hdr_idx_q;
	assign idx_inc = {1'b0, hdr_idx_q} + 6'd1;

	// Header byte store: decides which header field the byte lands in.
	always_comb begin
		auth_n   = auth_q;
		ptype_n  = ptype_q;
		sess_n   = sess_q;
		seq_n    = seq_q;
		oem_n    = oem_q;
		len_n    = len_q;
		base     = (ptype_q[5:0] == ishp_pkg::PT_OEM_EXPLICIT) ?
			ishp_pkg::V2_BASE_OEM : ishp_pkg::V2_BASE;
		off      = idx - base;
		oem_lane = 3'(idx - ishp_pkg::V2_BASE);
		len_at   = (auth_q == ishp_pkg::AUTH_NONE) ?
			ishp_pkg::V15_LEN_AT : ishp_pkg::V15_LEN_AT_AUTH;
		if (idx == 5'd0) begin
			auth_n = b;
		end else if (auth_q == ishp_pkg::AUTH_RMCPP) begin
			if (idx == 5'd1) begin
				ptype_n = b;
			end else if (idx < base) begin
				oem_n[{oem_lane, 3'b000} +: 8] = b;
			end else if (off < 5'd4) begin
				sess_n[{off[1:0], 3'b000} +: 8] = b;
			end else if (off < 5'd8) begin
				seq_n[{off[1:0], 3'b000} +: 8] = b;
			end else if (off < 5'd10) begin
				len_n[{off[0], 3'b000} +: 8] = b;
			end
		end else begin
			if (idx >= 5'd1 && idx <= 5'd4) begin
				seq_n[{2'(idx - 5'd1), 3'b000} +: 8] = b;
			end else if (idx >= 5'd5 && idx <= 5'd8) begin
				sess_n[{2'(idx - 5'd5), 3'b000} +: 8] = b;
			end else if (idx == len_at) begin
				len_n = {8'h00, b};
			end
		end
	end

	// Header length follows from the authentication and payload types,
	// including a type byte that arrives with this very item.
	always_comb begin
		v2_n      = (auth_n == ishp_pkg::AUTH_RMCPP);
		oem_sel_n = v2_n && (ptype_n[5:0] == ishp_pkg::PT_OEM_EXPLICIT);
		if (v2_n) begin
			hlen = oem_sel_n ? ishp_pkg::HLEN_V2_OEM : ishp_pkg::HLEN_V2;
		end else begin
			hlen = (auth_n == ishp_pkg::AUTH_NONE) ?
				ishp_pkg::HLEN_V15 : ishp_pkg::HLEN_V15_AUTH;
		end
		hdr_done = (idx_inc >= {1'b0, hlen});
		pt       = v2_n ? ptype_n : 8'h00;
		rem_dec  = remain_q - 16'd1;
	end

	// Result and next phase for the byte in the input register.
	always_comb begin
		res            = '0;
		res.final_item = eop;
		has_res        = 1'b1;
		phase_n        = phase_q;
		hdr_idx_n      = hdr_idx_q;
		remain_n       = remain_q;
		case (phase_q)
			ishp_pkg::PH_HEADER: begin
				if (hdr_done) begin
					res.kind             = ishp_pkg::KIND_HEADER;
					res.session_number   = sess_n;
					res.sequence_number  = seq_n;
					res.auth_kind        = auth_n;
					res.payload_kind     = pt[5:0];
					res.is_authenticated = pt[6];
					res.is_encrypted     = pt[7];
					res.message_length   = len_n;
					// Encrypted or non-IPMI RMCP+ payloads go to the raw handler.
					res.route            = pt[7] || (v2_n && pt[5:0] != 6'd0);
					res.oem_fields       = oem_sel_n ? oem_n : 48'd0;
					remain_n             = len_n;
					phase_n   = (len_n != 16'd0) ? ishp_pkg::PH_PAYLOAD :
						ishp_pkg::PH_TRAILER;
					hdr_idx_n = 5'd0;
				end else begin
					hdr_idx_n = idx_inc[4:0];
					res.kind  = ishp_pkg::KIND_HDR_TRUNC;
					has_res   = eop;
				end
			end
			ishp_pkg::PH_PAYLOAD: begin
				remain_n     = rem_dec;
				res.kind     = (eop && rem_dec != 16'd0) ? ishp_pkg::KIND_PLD_SHORT :
					ishp_pkg::KIND_PAYLOAD;
				res.byte_out = b;
				if (rem_dec == 16'd0) begin
					phase_n = ishp_pkg::PH_TRAILER;
				end
			end
			ishp_pkg::PH_TRAILER: begin
				res.kind     = ishp_pkg::KIND_TRAILER;
				res.byte_out = b;
			end
			default: begin
				has_res = 1'b0;
				phase_n = ishp_pkg::PH_HEADER;
			end
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_item;
		end
	end

	// Parse state; every end-of-packet returns it to the header start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ishp_pkg::PH_HEADER;
			hdr_idx_q <= '0;
			auth_q    <= '0;
			ptype_q   <= '0;
			sess_q    <= '0;
			seq_q     <= '0;
			oem_q     <= '0;
			len_q     <= '0;
			remain_q  <= '0;
		end else if (valid_s1 && adv) begin
			if (eop) begin
				phase_q   <= ishp_pkg::PH_HEADER;
				hdr_idx_q <= '0;
				auth_q    <= '0;
				ptype_q   <= '0;
				sess_q    <= '0;
				seq_q     <= '0;
				oem_q     <= '0;
				len_q     <= '0;
				remain_q  <= '0;
			end else begin
				phase_q   <= phase_n;
				hdr_idx_q <= hdr_idx_n;
				remain_q  <= remain_n;
				if (phase_q == ishp_pkg::PH_HEADER) begin
					auth_q  <= auth_n;
					ptype_q <= ptype_n;
					sess_q  <= sess_n;
					seq_q   <= seq_n;
					oem_q   <= oem_n;
					len_q   <= len_n;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && has_res) begin
			res_s2 <= res;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp_item  = res_s2;

	// Outside the header phase the header offset is always back at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != ishp_pkg::PH_HEADER |-> hdr_idx_q == 5'd0)
		else $error("header offset not cleared after header");

	// The payload phase is only held while payload bytes remain.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ishp_pkg::PH_PAYLOAD |-> remain_q != 16'd0)
		else $error("payload phase with zero bytes remaining");

	// A byte held in the input register by a full result stage is kept.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a waiting byte");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the IPMI session header parser.
// Drives session wrapper bytes on the request channel and checks every result
// against a byte-level predictor of the header parse. Depends on ishp_pkg.

module testbench;

	// Run sizes and waits. Every wait that either side inserts is drawn from
	// zero up to MAX_WAIT.
	localparam int RANDOM_BYTES = 625;
	localparam int MAX_WAIT     = 11;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// Header layouts that the packet builder can produce.
	typedef enum int {
		LAYOUT_V15,
		LAYOUT_V15_AUTH,
		LAYOUT_V2,
		LAYOUT_V2_OEM
	} packet_layout_t;

	// Where a generated packet ends.
	typedef enum int {
		END_IN_HEADER,
		END_AT_HEADER,
		END_CUT_PAYLOAD,
		END_FULL
	} packet_end_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ishp_pkg::req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ishp_pkg::rsp_t rsp_item;

	ipmi_session_header_parser_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// Results predicted but not yet seen on the response channel, oldest first.
	ishp_pkg::rsp_t expected_headers_and_bytes[$];

	// Clock with a period of 12 time units, and a cycle counter that stops a
	// hung run long after the slowest correct run would have finished.
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still awaited", $time,
				cycle_count, expected_headers_and_bytes.size());
			$display("** ipmi_session_header_parser_top: FAILED **");
			$finish;
		end
	end

	// Bookkeeping for the summary and the verdict.
	int error_count       = 0;
	int results_checked   = 0;
	int bytes_sent        = 0;
	int packets_sent      = 0;
	int truncated_headers = 0;
	int short_payloads    = 0;

	// When cleared, neither side inserts any wait, so the block runs at full
	// rate for a while. The random test flips it per packet.
	bit idle_enabled = 1'b1;

	function automatic int draw_wait();
		return idle_enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	// ------------------------------------------------------------------
	// Header parse predictor. It tracks the same per-packet state as the
	// block: parse phase, offset within the header, the header fields seen so
	// far and the count of payload bytes still due.
	// ------------------------------------------------------------------
	ishp_pkg::phase_t parse_phase = ishp_pkg::PH_HEADER;
	logic [4:0]  hdr_pos      = '0;
	logic [7:0]  auth_byte    = '0;
	logic [7:0]  ptype_byte   = '0;
	logic [31:0] session_word = '0;
	logic [31:0] seq_num      = '0;
	logic [47:0] oem_bytes    = '0;
	logic [15:0] msg_len      = '0;
	logic [15:0] payload_left = '0;

	function automatic void clear_parse();
		parse_phase  = ishp_pkg::PH_HEADER;
		hdr_pos      = '0;
		auth_byte    = '0;
		ptype_byte   = '0;
		session_word = '0;
		seq_num      = '0;
		oem_bytes    = '0;
		msg_len      = '0;
		payload_left = '0;
	endfunction

	function automatic logic is_rmcpp();
		return auth_byte == ishp_pkg::AUTH_RMCPP;
	endfunction

	function automatic logic is_oem_explicit();
		return is_rmcpp() && ptype_byte[5:0] == ishp_pkg::PT_OEM_EXPLICIT;
	endfunction

	// Header length follows from what has been stored so far, so it is
	// evaluated after the current byte is taken.
	function automatic logic [4:0] header_len();
		if (is_rmcpp())
			return is_oem_explicit() ? ishp_pkg::HLEN_V2_OEM : ishp_pkg::HLEN_V2;
		return auth_byte == ishp_pkg::AUTH_NONE ? ishp_pkg::HLEN_V15 :
			ishp_pkg::HLEN_V15_AUTH;
	endfunction

	function automatic void take_header_byte(logic [4:0] pos, logic [7:0] b);
		logic [4:0] base;
		logic [4:0] len_at;
		if (pos == 0) begin
			auth_byte = b;
		end else if (is_rmcpp()) begin
			if (pos == 1) begin
				ptype_byte = b;
			end else begin
				base = is_oem_explicit() ? ishp_pkg::V2_BASE_OEM : ishp_pkg::V2_BASE;
				if (pos < base)
					oem_bytes[(pos - ishp_pkg::V2_BASE) * 8 +: 8] = b;
				else if (pos < base + 4)
					session_word[(pos - base) * 8 +: 8] = b;
				else if (pos < base + 8)
					seq_num[(pos - base - 4) * 8 +: 8] = b;
				else if (pos < base + 10)
					msg_len[(pos - base - 8) * 8 +: 8] = b;
			end
		end else begin
			// v1.5: sequence first, then session ID; authcode bytes are dropped.
			len_at = auth_byte == ishp_pkg::AUTH_NONE ? ishp_pkg::V15_LEN_AT :
				ishp_pkg::V15_LEN_AT_AUTH;
			if (pos >= 1 && pos <= 4)
				seq_num[(pos - 1) * 8 +: 8] = b;
			else if (pos >= 5 && pos <= 8)
				session_word[(pos - 5) * 8 +: 8] = b;
			else if (pos == len_at)
				msg_len = {8'h00, b};
		end
	endfunction

	function automatic void predict_byte(ishp_pkg::req_t item);
		ishp_pkg::rsp_t r;
		logic emit;
		r = '0;
		r.final_item = item.end_of_packet;
		emit = 1'b1;
		case (parse_phase)
			ishp_pkg::PH_HEADER: begin
				take_header_byte(hdr_pos, item.data_byte);
				if (hdr_pos + 1 >= header_len()) begin
					r.kind            = ishp_pkg::KIND_HEADER;
					r.session_number  = session_word;
					r.sequence_number = seq_num;
					r.auth_kind       = auth_byte;
					r.message_length  = msg_len;
					if (is_rmcpp()) begin
						r.payload_kind     = ptype_byte[5:0];
						r.is_authenticated = ptype_byte[6];
						r.is_encrypted     = ptype_byte[7];
					end
					// Encrypted or non-IPMI RMCP+ payloads go to the raw handler.
					r.route = r.is_encrypted || (is_rmcpp() && r.payload_kind != 6'd0);
					if (is_oem_explicit())
						r.oem_fields = oem_bytes;
					payload_left = msg_len;
					parse_phase  = msg_len != 16'd0 ? ishp_pkg::PH_PAYLOAD :
						ishp_pkg::PH_TRAILER;
					hdr_pos      = '0;
				end else begin
					hdr_pos = hdr_pos + 5'd1;
					if (item.end_of_packet) begin
						r.kind = ishp_pkg::KIND_HDR_TRUNC;
						truncated_headers++;
					end else begin
						emit = 1'b0;
					end
				end
			end
			ishp_pkg::PH_PAYLOAD: begin
				payload_left = payload_left - 16'd1;
				r.byte_out   = item.data_byte;
				if (item.end_of_packet && payload_left != 16'd0) begin
					r.kind = ishp_pkg::KIND_PLD_SHORT;
					short_payloads++;
				end else begin
					r.kind = ishp_pkg::KIND_PAYLOAD;
				end
				if (payload_left == 16'd0)
					parse_phase = ishp_pkg::PH_TRAILER;
			end
			default: begin
				r.kind     = ishp_pkg::KIND_TRAILER;
				r.byte_out = item.data_byte;
			end
		endcase
		if (emit)
			expected_headers_and_bytes.push_back(r);
		if (item.end_of_packet)
			clear_parse();
	endfunction

	// ------------------------------------------------------------------
	// Result checking. Each accepted result is matched against the oldest
	// prediction field by field; a result with nothing predicted is an error.
	// ------------------------------------------------------------------
	function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic check_result(ishp_pkg::rsp_t got);
		ishp_pkg::rsp_t want;
		int bad;
		if (expected_headers_and_bytes.size() == 0) begin
			$display("%0t: unexpected result: expected none, got 0x%0h", $time, got);
			error_count++;
		end else begin
			want = expected_headers_and_bytes.pop_front();
			bad = field_differs("kind", want.kind, got.kind)
				+ field_differs("byte_out", want.byte_out, got.byte_out)
				+ field_differs("final_item", want.final_item, got.final_item)
				+ field_differs("session_number", want.session_number, got.session_number)
				+ field_differs("sequence_number", want.sequence_number, got.sequence_number)
				+ field_differs("auth_kind", want.auth_kind, got.auth_kind)
				+ field_differs("payload_kind", want.payload_kind, got.payload_kind)
				+ field_differs("is_authenticated", want.is_authenticated,
					got.is_authenticated)
				+ field_differs("is_encrypted", want.is_encrypted, got.is_encrypted)
				+ field_differs("message_length", want.message_length, got.message_length)
				+ field_differs("route", want.route, got.route)
				+ field_differs("oem_fields", want.oem_fields, got.oem_fields);
			if (bad != 0)
				error_count++;
			results_checked++;
		end
	endtask

	// Receiver. Outputs are sampled right after the rising edge, before the
	// block's own updates from that edge land, so the values seen are the ones
	// the edge acted on. After each accepted result a fresh stall length is
	// drawn, and the stall counts down whether or not a result is waiting, so
	// stalls fall on every phase of the parse.
	initial begin : result_receiver
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				check_result(rsp_item);
				hold = draw_wait();
			end else if (hold > 0) begin
				hold--;
			end
			rsp_stall <= hold > 0;
		end
	end

	// ------------------------------------------------------------------
	// Sender. One item per call: an optional gap with valid low, then valid
	// high until the block takes the item. With no gap, valid simply stays
	// high and only the payload changes, so valid gets one assignment per step.
	// ------------------------------------------------------------------
	task automatic send_byte(logic [7:0] value, logic is_last);
		ishp_pkg::req_t item;
		int gap;
		item.data_byte     = value;
		item.end_of_packet = is_last;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= item;
		do @(posedge clk); while (req_stall);
		predict_byte(item);
		bytes_sent++;
	endtask

	// Bytes of the packet being assembled; send_packet marks the last one.
	logic [7:0] pkt_bytes[$];

	task automatic send_packet();
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		pkt_bytes.delete();
		packets_sent++;
	endtask

	function automatic void push_le(logic [63:0] value, int count);
		for (int i = 0; i < count; i++)
			pkt_bytes.push_back(value[i * 8 +: 8]);
	endfunction

	// Appends a complete header of the layout that the auth and payload type
	// bytes select. The v1.5 length is one byte, so only len[7:0] is sent there.
	function automatic void build_header(logic [7:0] auth, logic [7:0] ptype,
			logic [31:0] sess, logic [31:0] seq, logic [47:0] oem, logic [15:0] len);
		pkt_bytes.push_back(auth);
		if (auth == ishp_pkg::AUTH_RMCPP) begin
			pkt_bytes.push_back(ptype);
			if (ptype[5:0] == ishp_pkg::PT_OEM_EXPLICIT)
				push_le(oem, 6);
			push_le(sess, 4);
			push_le(seq, 4);
			push_le(len, 2);
		end else begin
			push_le(seq, 4);
			push_le(sess, 4);
			if (auth != ishp_pkg::AUTH_NONE)
				repeat (16) pkt_bytes.push_back(8'($urandom_range(0, 255)));
			pkt_bytes.push_back(len[7:0]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// A packet of one byte ends inside the header.
	task automatic test_header_truncated();
		pkt_bytes.push_back(8'hFF);
		send_packet();
	endtask

	// A v1.5 header with no authcode, all-ones session fields and a zero
	// length; the packet ends on its last header byte.
	task automatic test_zero_length_header_ends_packet();
		build_header(ishp_pkg::AUTH_NONE, 8'h00, '1, '1, '0, 16'h0000);
		send_packet();
	endtask

	// An encrypted RMCP+ header with every payload type bit set and the
	// largest length, followed by one payload byte that ends the packet.
	task automatic test_payload_cut_short();
		build_header(ishp_pkg::AUTH_RMCPP, 8'hFF, '0, '0, '0, 16'hFFFF);
		pkt_bytes.push_back(8'hFF);
		send_packet();
	endtask

	// Mostly well-formed packets of all four layouts with random contents and
	// endings, mixed with packets of random bytes. Lengths are kept small so
	// that payloads usually complete; large lengths end early instead.
	task automatic test_random_packets();
		int start;
		int eff_len;
		int n;
		int keep;
		int pick;
		packet_layout_t layout;
		packet_end_t ending;
		logic [7:0] auth;
		logic [7:0] ptype;
		logic [15:0] len;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			idle_enabled = $urandom_range(0, 4) != 0;
			if ($urandom_range(0, 6) == 0) begin
				// Noise: a packet of arbitrary bytes, which may end anywhere.
				n = $urandom_range(1, 30);
				repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				layout = packet_layout_t'($urandom_range(0, 3));
				ptype  = 8'($urandom_range(0, 255));
				case (layout)
					LAYOUT_V15: begin
						auth = ishp_pkg::AUTH_NONE;
					end
					LAYOUT_V15_AUTH: begin
						do auth = 8'($urandom_range(1, 255));
						while (auth == ishp_pkg::AUTH_RMCPP);
					end
					LAYOUT_V2: begin
						auth = ishp_pkg::AUTH_RMCPP;
						// Favor the IPMI message type so that both routes show up.
						if (ptype[5:0] == ishp_pkg::PT_OEM_EXPLICIT ||
								$urandom_range(0, 2) == 0)
							ptype[5:0] = '0;
					end
					default: begin
						auth = ishp_pkg::AUTH_RMCPP;
						ptype[5:0] = ishp_pkg::PT_OEM_EXPLICIT;
					end
				endcase
				len = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6));
				build_header(auth, ptype, $urandom, $urandom, 48'({$urandom, $urandom}),
					len);
				eff_len = auth == ishp_pkg::AUTH_RMCPP ? int'(len) : int'(len[7:0]);

				pick = $urandom_range(0, 9);
				if (pick == 0)
					ending = END_IN_HEADER;
				else if (pick == 1)
					ending = END_AT_HEADER;
				else if (pick == 2)
					ending = END_CUT_PAYLOAD;
				else
					ending = END_FULL;

				if (ending == END_IN_HEADER) begin
					keep = $urandom_range(1, pkt_bytes.size() - 1);
					while (pkt_bytes.size() > keep)
						void'(pkt_bytes.pop_back());
				end else if (ending != END_AT_HEADER) begin
					// Long payloads are always cut; short ones are sent whole
					// with a few trailer bytes unless a cut was asked for.
					if (eff_len > 8 || (ending == END_CUT_PAYLOAD && eff_len > 1))
						n = $urandom_range(1, eff_len > 8 ? 8 : eff_len - 1);
					else
						n = eff_len + $urandom_range(0, 3);
					repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
				end
			end
			send_packet();
		end
		idle_enabled = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence: reset once, run the tests in turn, then drain and report.
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_truncated();
		test_zero_length_header_ends_packet();
		test_payload_cut_short();
		test_random_packets();

		// The last item was taken at this edge; drop valid and wait for the
		// outstanding results, then a little longer to catch any extras.
		req_valid <= 1'b0;
		while (expected_headers_and_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d packets (%0d bytes); checked %0d results in %0d cycles.",
			packets_sent, bytes_sent, results_checked, cycle_count);
		$display("Packets ending in the header: %0d, payloads cut short: %0d, errors: %0d.",
			truncated_headers, short_payloads, error_count);
		if (error_count == 0) begin
			$display("** ipmi_session_header_parser_top: PASSED **");
		end else begin
			$display("** ipmi_session_header_parser_top: FAILED **");
		end
		$finish;
	end

endmodule
